/* src/m3i_pkg.sv */
// shared widths, cofactor index tables and lane types for the 3x3 inverse
package m3i_pkg;

  localparam int ENT_W = 32;
  localparam int PROD_W = 2 * ENT_W;
  localparam int ADJ_W = PROD_W + 1;
  localparam int DET_W = 98;
  localparam int FRAC_W = 16;
  localparam int QUO_W = 2 * FRAC_W;
  localparam int REM_W = ADJ_W + QUO_W;
  localparam int CMP_W = DET_W + QUO_W;
  localparam int NENT = 9;
  localparam int NROW = 3;
  localparam int FRONT_STAGES = 6;
  localparam int DIV_STAGES = QUO_W + 2;
  localparam int NSTAGE = FRONT_STAGES + DIV_STAGES;

  localparam logic [ENT_W-1:0] SAT_POS = {1'b0, {(ENT_W-1){1'b1}}};
  localparam logic [ENT_W-1:0] SAT_NEG = {1'b1, {(ENT_W-1){1'b0}}};

  // adj[k] = m[PA[k]]*m[PB[k]] - m[PC[k]]*m[PD[k]], entries indexed 3*row+col
  localparam int PA [NENT] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int PB [NENT] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int PC [NENT] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int PD [NENT] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  typedef struct packed {
    logic [DET_W-1:0] dmag;
    logic             dneg;
    logic             dzero;
  } det_info_t;

  typedef struct packed {
    logic [ENT_W-1:0] quo;
    logic             zero;
  } lane_out_t;

endpackage

/* src/m3i_div.sv */
// one division lane: trunc(adj * 2^32 / det) with saturation, one quotient bit per g_bit stage
module m3i_div import m3i_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [ADJ_W-1:0] adj,
  input  det_info_t               det,
  output lane_out_t               res
);

  logic [REM_W-1:0] rem [DIV_STAGES];
  logic [QUO_W-1:0] q   [DIV_STAGES];
  logic [DET_W-1:0] dm  [DIV_STAGES];
  logic             ng  [DIV_STAGES];
  logic             sat [DIV_STAGES];
  logic             zr  [DIV_STAGES];
  logic [ADJ_W-1:0] amag;

  assign amag = adj[ADJ_W-1] ? ADJ_W'(-adj) : ADJ_W'(adj);

  // magnitude and sign
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= {amag, {QUO_W{1'b0}}};
      q[0]   <= '0;
      dm[0]  <= det.dmag;
      ng[0]  <= det.dneg ^ adj[ADJ_W-1];
      sat[0] <= 1'b0;
      zr[0]  <= det.dzero;
    end
  end

  // quotient of 2^32 or more saturates
  always_ff @(posedge clk) begin
    if (en) begin
      rem[1] <= rem[0];
      q[1]   <= q[0];
      dm[1]  <= dm[0];
      ng[1]  <= ng[0];
      sat[1] <= CMP_W'(rem[0]) >= {dm[0], {QUO_W{1'b0}}};
      zr[1]  <= zr[0];
    end
  end

  for (genvar j = 2; j < DIV_STAGES; j++) begin : g_bit
    localparam int B = DIV_STAGES - 1 - j;
    logic [CMP_W-1:0] sh;
    logic [CMP_W-1:0] diff;
    logic             ge;
    assign sh   = CMP_W'(dm[j-1]) << B;
    assign ge   = CMP_W'(rem[j-1]) >= sh;
    assign diff = CMP_W'(rem[j-1]) - sh;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j] <= ge ? diff[REM_W-1:0] : rem[j-1];
        q[j]   <= q[j-1] | (ge ? (QUO_W'(1) << B) : QUO_W'(0));
        dm[j]  <= dm[j-1];
        ng[j]  <= ng[j-1];
        sat[j] <= sat[j-1];
        zr[j]  <= zr[j-1];
      end
    end
  end

  always_comb begin
    res.zero = zr[DIV_STAGES-1];
    if (zr[DIV_STAGES-1]) begin
      res.quo = '0;
    end else if (!ng[DIV_STAGES-1]) begin
      res.quo = (sat[DIV_STAGES-1] || q[DIV_STAGES-1][QUO_W-1]) ? SAT_POS
                                                                : q[DIV_STAGES-1];
    end else begin
      res.quo = (sat[DIV_STAGES-1] || q[DIV_STAGES-1] > SAT_NEG) ? SAT_NEG
                                                                 : -q[DIV_STAGES-1];
    end
  end

endmodule

/* src/matrix3_inverse.sv */
// top level: pipelined 3x3 Q16.16 matrix inverse by adjugate over determinant
//
//  channel  handshake       fields
//  matrix   m_valid/m_stall m00 .. m22, signed Q16.16
//  inverse  inv_valid/      inv00 .. inv22 signed Q16.16, invertible
//           inv_stall
//
// one item per cycle while m_stall is low
// six arithmetic stages (products, cofactors, partial products, terms,
// determinant, magnitude) then 34 divider stages (magnitude, saturation check, then one quotient bit each)
// a skid register behind the output register; m_stall is that skid being full
// rst clears the valid bits only
module matrix3_inverse import m3i_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    m_valid,
  output logic                    m_stall,
  input  logic signed [ENT_W-1:0] m00,
  input  logic signed [ENT_W-1:0] m01,
  input  logic signed [ENT_W-1:0] m02,
  input  logic signed [ENT_W-1:0] m10,
  input  logic signed [ENT_W-1:0] m11,
  input  logic signed [ENT_W-1:0] m12,
  input  logic signed [ENT_W-1:0] m20,
  input  logic signed [ENT_W-1:0] m21,
  input  logic signed [ENT_W-1:0] m22,
  output logic                    inv_valid,
  input  logic                    inv_stall,
  output logic signed [ENT_W-1:0] inv00,
  output logic signed [ENT_W-1:0] inv01,
  output logic signed [ENT_W-1:0] inv02,
  output logic signed [ENT_W-1:0] inv10,
  output logic signed [ENT_W-1:0] inv11,
  output logic signed [ENT_W-1:0] inv12,
  output logic signed [ENT_W-1:0] inv20,
  output logic signed [ENT_W-1:0] inv21,
  output logic signed [ENT_W-1:0] inv22,
  output logic                    invertible
);

  logic signed [ENT_W-1:0]  mi [NENT];
  logic signed [PROD_W-1:0] pa [NENT];
  logic signed [PROD_W-1:0] pb [NENT];
  logic signed [ENT_W-1:0]  c1 [NROW];
  logic signed [ENT_W-1:0]  c2 [NROW];
  logic signed [ADJ_W-1:0]  a2 [NENT];
  logic signed [ADJ_W-1:0]  a3 [NENT];
  logic signed [ADJ_W-1:0]  a4 [NENT];
  logic signed [ADJ_W-1:0]  a5 [NENT];
  logic signed [ADJ_W-1:0]  a6 [NENT];
  logic signed [ADJ_W-1:0]  lp [NROW];
  logic signed [ADJ_W-1:0]  hp [NROW];
  logic signed [DET_W-1:0]  tm [NROW];
  logic signed [DET_W-1:0]  det;
  det_info_t                dinfo;
  lane_out_t                lane [NENT];
  logic [NSTAGE-1:0]        pv;
  logic                     en;
  logic                     ov;
  logic                     sv;
  logic                     take;
  logic                     arrive;
  logic [ENT_W-1:0]         pin [NENT];
  logic [ENT_W-1:0]         od [NENT];
  logic [ENT_W-1:0]         sk [NENT];
  logic                     pinv;
  logic                     oinv;
  logic                     skinv;
  logic [NENT-1:0]          zl;

  assign mi[0] = m00;
  assign mi[1] = m01;
  assign mi[2] = m02;
  assign mi[3] = m10;
  assign mi[4] = m11;
  assign mi[5] = m12;
  assign mi[6] = m20;
  assign mi[7] = m21;
  assign mi[8] = m22;

  assign en      = !sv;
  assign m_stall = sv;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else if (en) begin
      pv <= {pv[NSTAGE-2:0], m_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NENT; k++) begin
        pa[k] <= mi[PA[k]] * mi[PB[k]];
        pb[k] <= mi[PC[k]] * mi[PD[k]];
        a2[k] <= ADJ_W'(pa[k]) - ADJ_W'(pb[k]);
        a3[k] <= a2[k];
        a4[k] <= a3[k];
        a5[k] <= a4[k];
        a6[k] <= a5[k];
      end
      for (int r = 0; r < NROW; r++) begin
        c1[r] <= mi[r];
        c2[r] <= c1[r];
        // first-row entry times cofactor, split at bit 32
        lp[r] <= c2[r] * $signed({1'b0, a2[NROW*r][QUO_W-1:0]});
        hp[r] <= c2[r] * $signed(a2[NROW*r][ADJ_W-1:QUO_W]);
        tm[r] <= (DET_W'(hp[r]) <<< QUO_W) + DET_W'(lp[r]);
      end
      det         <= tm[0] + tm[1] + tm[2];
      dinfo.dmag  <= det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
      dinfo.dneg  <= det[DET_W-1];
      dinfo.dzero <= det == '0;
    end
  end

  for (genvar k = 0; k < NENT; k++) begin : g_lane
    m3i_div u_div (
      .clk (clk),
      .en  (en),
      .adj (a6[k]),
      .det (dinfo),
      .res (lane[k])
    );
    assign pin[k] = lane[k].quo;
    assign zl[k]  = lane[k].zero;
  end

  assign pinv   = !(|zl);
  assign take   = !ov || !inv_stall;
  assign arrive = pv[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (sv) begin
      if (take) begin
        ov <= 1'b1;
        sv <= 1'b0;
      end
    end else if (arrive) begin
      if (take) begin
        ov <= 1'b1;
      end else begin
        sv <= 1'b1;
      end
    end else if (take) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sv && take) begin
      od   <= sk;
      oinv <= skinv;
    end else if (!sv && arrive && take) begin
      od   <= pin;
      oinv <= pinv;
    end
    if (!sv && arrive && !take) begin
      sk    <= pin;
      skinv <= pinv;
    end
  end

  assign inv_valid  = ov;
  assign invertible = oinv;
  assign inv00      = od[0];
  assign inv01      = od[1];
  assign inv02      = od[2];
  assign inv10      = od[3];
  assign inv11      = od[4];
  assign inv12      = od[5];
  assign inv20      = od[6];
  assign inv21      = od[7];
  assign inv22      = od[8];

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    sv |-> ov) else $error("skid holds an item while output is empty");

  a_frozen: assert property (@(posedge clk) disable iff (rst)
    sv |=> $stable(pv)) else $error("pipeline moved while skid full");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (ov && !oinv) |-> (od[0] == '0 && od[1] == '0 && od[2] == '0 &&
                       od[3] == '0 && od[4] == '0 && od[5] == '0 &&
                       od[6] == '0 && od[7] == '0 && od[8] == '0))
    else $error("singular item with nonzero entries");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!ov && !sv && pv == '0)) else $error("reset left items in flight");
`endif

endmodule
